// ----- hdl/sdwt_pkg.sv -----
// Shared types and defaults for the sequence number duplicate window tracker.
// No dependencies.
package sdwt_pkg;

    localparam int DEF_RANGE_SLOTS = 64;
    localparam int DEF_BLOCK_COUNT = 8;
    localparam int DEF_SEQ_WIDTH   = 32;
    localparam logic [31:0] MAX_SEQNO_RESET = 32'd65535;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_DUP    = 3'd1,
        STAT_OUT    = 3'd2,
        STAT_REJECT = 3'd3,
        STAT_IDLE   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SSCAN,
        S_BND,
        S_CHK,
        S_SCAN,
        S_FOLD,
        S_INS,
        S_ADV,
        S_PRUNE,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        TAG_HEAD = 2'd0,
        TAG_TAIL = 2'd1,
        TAG_NEXT = 2'd2
    } btag_t;

endpackage

// ----- hdl/sdwt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/seqno_duplicate_window_tracker_top.sv -----
// Top level of the sequence number duplicate window tracker.
// Depends on sdwt_pkg and sdwt_ram.
//
// Received sequence numbers are kept as an ordered list of ranges in a ring held in one
// RAM (start and end per entry); a sliding window from a head block to the block
// BLOCK_COUNT/2 further on rejects numbers outside it. One item is handled at a time.
// Every item that is not rejected or answered idle first divides max_seqno by BLOCK_COUNT
// with a reciprocal multiply for the block size. A start then scans the blocks, one per
// cycle. An update computes the block bounds, then scans the ranges one per cycle, folds
// the back half of the list into one entry when the list is full, and prunes when the
// window advances; the range RAM has a single read and a single write port.
// The next item is accepted while the last result still waits on m_ready.
module seqno_duplicate_window_tracker_top #(
    parameter int RANGE_SLOTS = sdwt_pkg::DEF_RANGE_SLOTS,
    parameter int BLOCK_COUNT = sdwt_pkg::DEF_BLOCK_COUNT,
    parameter int SEQ_WIDTH   = sdwt_pkg::DEF_SEQ_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_seqno,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status
);

    import sdwt_pkg::*;

    localparam int SW   = SEQ_WIDTH;
    localparam int AW   = $clog2(RANGE_SLOTS);
    localparam int NW   = $clog2(RANGE_SLOTS + 1);
    localparam int BIW  = $clog2(BLOCK_COUNT);
    localparam int BCW  = $clog2(BLOCK_COUNT + 1);
    localparam int XW   = (SW > 32) ? SW : 32;
    localparam int PW   = (33 + BIW > SW) ? 33 + BIW : SW;
    localparam int POS  = RANGE_SLOTS / 2;
    localparam int HALF = BLOCK_COUNT / 2;
    localparam int DSH  = 32 + BIW;
    // ceil(2^DSH / BLOCK_COUNT): exact quotient for every 32-bit dividend
    localparam logic [32:0] DIV_RECIP =
        33'(((65'd1 << DSH) + 65'(BLOCK_COUNT - 1)) / 65'(BLOCK_COUNT));

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] b, input logic [AW-1:0] p);
        logic [AW:0] sum;
        sum = {1'b0, b} + {1'b0, p};
        if (sum >= (AW+1)'(RANGE_SLOTS)) begin
            sum = sum - (AW+1)'(RANGE_SLOTS);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [BIW-1:0] blk_inc(input logic [BIW-1:0] b);
        return (b == BIW'(BLOCK_COUNT - 1)) ? '0 : b + BIW'(1);
    endfunction

    function automatic logic [BIW-1:0] blk_half(input logic [BIW-1:0] b);
        logic [BIW:0] sum;
        sum = {1'b0, b} + (BIW+1)'(HALF);
        if (sum >= (BIW+1)'(BLOCK_COUNT)) begin
            sum = sum - (BIW+1)'(BLOCK_COUNT);
        end
        return sum[BIW-1:0];
    endfunction

    state_t state_reg, state_next;
    status_t status_reg, status_next;
    logic            mode_reg, mode_next;
    logic [SW-1:0]   seq_reg, seq_next;
    logic [31:0]     max_reg, max_next;
    logic [31:0]     q_reg, q_next;
    logic [BCW-1:0]  bi_reg, bi_next;
    logic [BIW-1:0]  head_reg, head_next;
    logic [BIW-1:0]  whb_reg, whb_next;
    logic [BIW-1:0]  wtb_reg, wtb_next;
    logic            started_reg, started_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   ic_reg, ic_next;
    logic            rv_reg, rv_next;
    logic [AW-1:0]   rj_reg, rj_next;
    logic [NW-1:0]   k_reg, k_next;
    logic [SW-1:0]   hb_reg, hb_next, ht_reg, ht_next;
    logic [SW-1:0]   th_reg, th_next, tt_reg, tt_next;
    logic [SW-1:0]   nh_reg, nh_next;
    logic [SW-1:0]   fs_reg, fs_next, fe_reg, fe_next;
    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg, m_status_next;

    logic            p1_v_reg, p2_v_reg;
    logic [BIW-1:0]  p1_i_reg, p2_i_reg;
    btag_t           p1_tag_reg, p2_tag_reg;
    logic [SW-1:0]   p1_h_reg, p2_h_reg, p2_t_reg;

    logic            bu_v;
    logic [BIW-1:0]  bu_idx;
    btag_t           bu_tag;
    logic [32:0]     sz1;
    logic [PW-1:0]   prod;
    logic [PW-1:0]   tail_sum;
    logic [64:0]     q_prod;
    logic [31:0]     q_div;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [2*SW-1:0] wdata, rdata;
    logic [SW-1:0]   rd_s, rd_e;

    logic [SW-1:0]   s_in, below, acc_s, acc_e;
    logic            iss, last, hit, inr, clip, drop;
    logic            out_win, in_tail;
    logic [BIW-1:0]  head_fin;

    sdwt_ram #(
        .WIDTH(2 * SW),
        .DEPTH(RANGE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_s = rdata[2*SW-1:SW];
    assign rd_e = rdata[SW-1:0];

    // block size = max_seqno / BLOCK_COUNT
    assign q_prod = 65'(q_reg) * 65'(DIV_RECIP);
    assign q_div  = 32'(q_prod >> DSH);

    // block bound pipe: head = idx * (size + 1), tail = head + size
    assign sz1      = {1'b0, q_reg} + 33'd1;
    assign prod     = PW'(bu_idx) * PW'(sz1);
    assign tail_sum = PW'(p1_h_reg) + PW'(q_reg);

    assign s_in    = SW'(s_seqno);
    assign below   = (seq_reg != '0) ? seq_reg - SW'(1) : '0;
    assign iss     = ic_reg < n_reg;
    assign last    = (NW'(rj_reg) + NW'(1)) == n_reg;
    assign hit     = (p2_h_reg <= seq_reg) && (seq_reg <= p2_t_reg);
    assign inr     = (hb_reg <= rd_s) && (rd_s <= ht_reg);
    assign clip    = inr && (ht_reg < rd_e);
    assign drop    = inr && !clip && ((k_reg != '0) || !last);
    assign out_win = (hb_reg < tt_reg) ? ((seq_reg < hb_reg) || (tt_reg < seq_reg))
                                       : ((tt_reg < seq_reg) && (seq_reg < hb_reg));
    assign in_tail = (th_reg <= seq_reg) && (seq_reg <= tt_reg);
    assign head_fin = (p2_v_reg && hit) ? p2_i_reg : head_reg;
    assign acc_s   = (NW'(rj_reg) == NW'(POS) || fs_reg < rd_s) ? rd_s : fs_reg;
    assign acc_e   = (NW'(rj_reg) == NW'(POS) || fe_reg < rd_e) ? rd_e : fe_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_mode) begin
                        if (max_reg == '0 || XW'(s_in) > XW'(max_reg)) begin
                            state_next = S_FIN;
                        end else begin
                            state_next = S_DIV;
                        end
                    end else if (!started_reg) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                state_next = mode_reg ? S_BND : S_SSCAN;
            end
            S_SSCAN: begin
                if (p2_v_reg && p2_i_reg == BIW'(BLOCK_COUNT - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_BND: begin
                if (p2_v_reg && p2_tag_reg == TAG_NEXT) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (out_win) begin
                    state_next = S_FIN;
                end else if (n_reg == '0) begin
                    state_next = S_INS;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rv_reg) begin
                    priority if ((rd_s <= seq_reg) && (seq_reg <= rd_e)) begin
                        state_next = S_FIN;
                    end else if (rd_e == below) begin
                        state_next = S_ADV;
                    end else if (last) begin
                        state_next = (n_reg == NW'(RANGE_SLOTS)) ? S_FOLD : S_INS;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_FOLD: begin
                if (rv_reg && last) begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                state_next = S_ADV;
            end
            S_ADV: begin
                state_next = in_tail ? S_PRUNE : S_FIN;
            end
            S_PRUNE: begin
                if (rv_reg && last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        status_next   = status_reg;
        mode_next     = mode_reg;
        seq_next      = seq_reg;
        max_next      = cfg_valid ? cfg_data : max_reg;
        q_next        = q_reg;
        bi_next       = bi_reg;
        head_next     = head_reg;
        whb_next      = whb_reg;
        wtb_next      = wtb_reg;
        started_next  = started_reg;
        base_next     = base_reg;
        n_next        = n_reg;
        ic_next       = ic_reg;
        rv_next       = 1'b0;
        rj_next       = rj_reg;
        k_next        = k_reg;
        hb_next       = hb_reg;
        ht_next       = ht_reg;
        th_next       = th_reg;
        tt_next       = tt_reg;
        nh_next       = nh_reg;
        fs_next       = fs_reg;
        fe_next       = fe_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        bu_v          = 1'b0;
        bu_idx        = '0;
        bu_tag        = TAG_HEAD;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = ring(base_reg, ic_reg[AW-1:0]);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    seq_next  = s_in;
                    q_next    = max_reg;
                    bi_next   = '0;
                    head_next = '0;
                    if (!s_mode && (max_reg == '0 || XW'(s_in) > XW'(max_reg))) begin
                        status_next = STAT_REJECT;
                    end else if (s_mode && !started_reg) begin
                        status_next = STAT_IDLE;
                    end
                end
            end
            S_DIV: begin
                q_next = q_div;
            end
            S_SSCAN: begin
                if (bi_reg < BCW'(BLOCK_COUNT)) begin
                    bu_v    = 1'b1;
                    bu_idx  = bi_reg[BIW-1:0];
                    bi_next = bi_reg + BCW'(1);
                end
                head_next = head_fin;
                if (p2_v_reg && p2_i_reg == BIW'(BLOCK_COUNT - 1)) begin
                    whb_next     = head_fin;
                    wtb_next     = blk_half(head_fin);
                    base_next    = '0;
                    n_next       = NW'(1);
                    started_next = 1'b1;
                    we           = 1'b1;
                    waddr        = '0;
                    wdata        = {seq_reg, seq_reg};
                    status_next  = STAT_OK;
                end
            end
            S_BND: begin
                if (bi_reg < BCW'(3)) begin
                    bu_v    = 1'b1;
                    bi_next = bi_reg + BCW'(1);
                    unique case (bi_reg)
                        BCW'(0): begin
                            bu_idx = whb_reg;
                            bu_tag = TAG_HEAD;
                        end
                        BCW'(1): begin
                            bu_idx = wtb_reg;
                            bu_tag = TAG_TAIL;
                        end
                        default: begin
                            bu_idx = blk_inc(whb_reg);
                            bu_tag = TAG_NEXT;
                        end
                    endcase
                end
                if (p2_v_reg) begin
                    unique case (p2_tag_reg)
                        TAG_HEAD: begin
                            hb_next = p2_h_reg;
                            ht_next = p2_t_reg;
                        end
                        TAG_TAIL: begin
                            th_next = p2_h_reg;
                            tt_next = p2_t_reg;
                        end
                        default: nh_next = p2_h_reg;
                    endcase
                end
            end
            S_CHK: begin
                ic_next = '0;
                if (out_win) begin
                    status_next = STAT_OUT;
                end
            end
            S_SCAN: begin
                if (iss) begin
                    rv_next = 1'b1;
                    rj_next = ic_reg[AW-1:0];
                    ic_next = ic_reg + NW'(1);
                end
                if (rv_reg) begin
                    priority if ((rd_s <= seq_reg) && (seq_reg <= rd_e)) begin
                        status_next = STAT_DUP;
                        rv_next     = 1'b0;
                    end else if (rd_e == below) begin
                        we      = 1'b1;
                        waddr   = ring(base_reg, rj_reg);
                        wdata   = {rd_s, seq_reg};
                        rv_next = 1'b0;
                    end else if (last) begin
                        rv_next = 1'b0;
                        ic_next = NW'(POS);
                    end else begin
                        rv_next = rv_next;
                    end
                end
            end
            S_FOLD: begin
                if (iss) begin
                    rv_next = 1'b1;
                    rj_next = ic_reg[AW-1:0];
                    ic_next = ic_reg + NW'(1);
                end
                if (rv_reg) begin
                    fs_next = acc_s;
                    fe_next = acc_e;
                    if (last) begin
                        we      = 1'b1;
                        waddr   = ring(base_reg, AW'(POS));
                        wdata   = {acc_s, acc_e};
                        n_next  = NW'(POS + 1);
                        rv_next = 1'b0;
                    end
                end
            end
            S_INS: begin
                base_next = (base_reg == '0) ? AW'(RANGE_SLOTS - 1) : base_reg - AW'(1);
                we        = 1'b1;
                waddr     = base_next;
                wdata     = {seq_reg, seq_reg};
                n_next    = n_reg + NW'(1);
            end
            S_ADV: begin
                ic_next     = '0;
                k_next      = '0;
                status_next = STAT_OK;
                if (in_tail) begin
                    whb_next = blk_inc(whb_reg);
                    wtb_next = blk_inc(wtb_reg);
                end
            end
            S_PRUNE: begin
                if (iss) begin
                    rv_next = 1'b1;
                    rj_next = ic_reg[AW-1:0];
                    ic_next = ic_reg + NW'(1);
                end
                if (rv_reg) begin
                    if (!drop) begin
                        we     = 1'b1;
                        waddr  = ring(base_reg, k_reg[AW-1:0]);
                        wdata  = {(clip ? nh_reg : rd_s), rd_e};
                        k_next = k_reg + NW'(1);
                    end
                    if (last) begin
                        n_next  = k_next;
                        rv_next = 1'b0;
                    end
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                end
            end
            default: begin
                rv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            max_reg     <= MAX_SEQNO_RESET;
            whb_reg     <= '0;
            wtb_reg     <= '0;
            started_reg <= 1'b0;
            base_reg    <= '0;
            n_reg       <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            max_reg     <= max_next;
            whb_reg     <= whb_next;
            wtb_reg     <= wtb_next;
            started_reg <= started_next;
            base_reg    <= base_next;
            n_reg       <= n_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
            p1_v_reg    <= bu_v;
            p2_v_reg    <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        mode_reg     <= mode_next;
        seq_reg      <= seq_next;
        q_reg        <= q_next;
        bi_reg       <= bi_next;
        head_reg     <= head_next;
        ic_reg       <= ic_next;
        rj_reg       <= rj_next;
        k_reg        <= k_next;
        hb_reg       <= hb_next;
        ht_reg       <= ht_next;
        th_reg       <= th_next;
        tt_reg       <= tt_next;
        nh_reg       <= nh_next;
        fs_reg       <= fs_next;
        fe_reg       <= fe_next;
        m_status_reg <= m_status_next;
        p1_i_reg     <= bu_idx;
        p1_tag_reg   <= bu_tag;
        p1_h_reg     <= prod[SW-1:0];
        p2_i_reg     <= p1_i_reg;
        p2_tag_reg   <= p1_tag_reg;
        p2_h_reg     <= p1_h_reg;
        p2_t_reg     <= tail_sum[SW-1:0];
    end

    a_list_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (started_reg && state_reg == S_IDLE) |-> (n_reg != '0 && n_reg <= NW'(RANGE_SLOTS)))
        else $error("range list size out of bounds");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

    a_window_span: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> (wtb_reg == blk_half(whb_reg)))
        else $error("window tail block out of step with head block");

endmodule

// ----- test/sdwt_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sequence number duplicate window tracker: watches the config,
// input and result channels, predicts each status and compares. Depends on sdwt_pkg.
module sdwt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_seqno,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    output int          fail_count,
    output int          pending
);

    import sdwt_pkg::*;

    localparam int SLOTS  = 64;
    localparam int BLOCKS = 8;

    logic [31:0] max_seqno;
    logic [31:0] rng_lo [SLOTS];
    logic [31:0] rng_hi [SLOTS];
    int          rng_next [SLOTS];
    int          list_head;
    bit          list_none;
    int          free_head;
    int          free_cnt;
    int          head_blk;
    int          tail_blk;
    bit          tracking;
    int          ord [SLOTS];
    status_t     status_q [$];

    function automatic logic [31:0] blk_head(int i);
        logic [63:0] sz;
        sz = {32'd0, max_seqno} / BLOCKS;
        return 32'(64'(i) * (sz + 64'd1));
    endfunction

    function automatic logic [31:0] blk_tail(int i);
        return blk_head(i) + max_seqno / BLOCKS;
    endfunction

    function automatic void free_slot(int e);
        rng_next[e] = free_head;
        free_head = e;
        free_cnt++;
    endfunction

    function automatic status_t track_status(bit mode, logic [31:0] s);
        logic [31:0] hb, tb, below, ohh, oht, nh;
        int n, cur, e, k, slot, keep, blk;
        bit hit, drop;
        if (!mode) begin
            if (max_seqno == 0 || s > max_seqno) return STAT_REJECT;
            blk = 0;
            for (int i = 0; i < BLOCKS; i++)
                if (blk_head(i) <= s && s <= blk_tail(i)) blk = i;
            head_blk = blk;
            tail_blk = (blk + BLOCKS / 2) % BLOCKS;
            for (int i = 1; i < SLOTS; i++) rng_next[i] = (i + 1) % SLOTS;
            free_head = 1;
            free_cnt = SLOTS - 1;
            rng_lo[0] = s;
            rng_hi[0] = s;
            rng_next[0] = 0;
            list_head = 0;
            list_none = 0;
            tracking = 1;
            return STAT_OK;
        end
        if (!tracking) return STAT_IDLE;
        hb = blk_head(head_blk);
        tb = blk_tail(tail_blk);
        below = (s > 0) ? s - 1 : 32'd0;
        if (hb < tb) begin
            if (s < hb || tb < s) return STAT_OUT;
        end else if (tb < s && s < hb) begin
            return STAT_OUT;
        end
        n = list_none ? 0 : SLOTS - free_cnt;
        cur = list_head;
        for (int j = 0; j < n; j++) begin
            ord[j] = cur;
            cur = rng_next[cur];
        end
        hit = 0;
        for (int j = 0; j < n; j++) begin
            e = ord[j];
            if (rng_lo[e] <= s && s <= rng_hi[e]) return STAT_DUP;
            if (rng_hi[e] == below) begin
                rng_hi[e] = s;
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            if (free_cnt == 0 && n > SLOTS / 2) begin
                keep = ord[SLOTS / 2];
                for (int j = SLOTS / 2 + 1; j < n; j++) begin
                    e = ord[j];
                    if (rng_lo[keep] < rng_lo[e]) rng_lo[keep] = rng_lo[e];
                    if (rng_hi[keep] < rng_hi[e]) rng_hi[keep] = rng_hi[e];
                    free_slot(e);
                end
                n = SLOTS / 2 + 1;
            end
            if (free_cnt == 0) return STAT_OK;
            slot = free_head;
            free_head = rng_next[slot];
            free_cnt--;
            rng_lo[slot] = s;
            rng_hi[slot] = s;
            for (int j = n; j > 0; j--) ord[j] = ord[j - 1];
            ord[0] = slot;
            n++;
        end
        if (!(s < blk_head(tail_blk) || blk_tail(tail_blk) < s)) begin
            ohh = blk_head(head_blk);
            oht = blk_tail(head_blk);
            head_blk = (head_blk + 1) % BLOCKS;
            tail_blk = (tail_blk + 1) % BLOCKS;
            nh = blk_head(head_blk);
            k = 0;
            for (int j = 0; j < n; j++) begin
                e = ord[j];
                drop = 0;
                if (ohh <= rng_lo[e] && rng_lo[e] <= oht) begin
                    if (oht < rng_hi[e]) rng_lo[e] = nh;
                    else if (k > 0 || j + 1 < n) drop = 1;
                end
                if (drop) free_slot(e);
                else begin
                    ord[k] = e;
                    k++;
                end
            end
            n = k;
        end
        list_none = (n == 0);
        if (n != 0) begin
            list_head = ord[0];
            for (int j = 0; j + 1 < n; j++) rng_next[ord[j]] = ord[j + 1];
            rng_next[ord[n - 1]] = 0;
        end
        return STAT_OK;
    endfunction

    assign pending = status_q.size();

    always @(posedge aclk) begin
        status_t want;
        if (!aresetn) begin
            max_seqno <= MAX_SEQNO_RESET;
            list_head = 0;
            list_none = 1;
            free_head = 0;
            free_cnt = 0;
            head_blk = 0;
            tail_blk = 0;
            tracking = 0;
            status_q.delete();
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result: status %0d", m_status);
                end else begin
                    want = status_q.pop_front();
                    if (m_status !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("status mismatch: expected %0d actual %0d",
                                     want, m_status);
                    end
                end
            end
            if (s_valid && s_ready)
                status_q.push_back(track_status(s_mode, s_seqno));
            if (cfg_valid && cfg_ready) max_seqno <= cfg_data;
        end
    end

endmodule

// ----- test/tb_seqno_duplicate_window_tracker_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the sequence number duplicate window tracker: clock, reset,
// stimulus and verdict. Depends on sdwt_pkg, sdwt_checker and the block.
module tb_seqno_duplicate_window_tracker_top;
    import sdwt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_mode = 0;
    logic [31:0] s_seqno = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [31:0] cur_max = MAX_SEQNO_RESET;

    always #6 aclk = ~aclk;

    seqno_duplicate_window_tracker_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_seqno(s_seqno),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status)
    );

    sdwt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_seqno(s_seqno),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(bit mode, logic [31:0] seq);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1;
        s_mode  <= mode;
        s_seqno <= seq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_max(logic [31:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        cur_max = v;
    endtask

    task automatic random_run(int count);
        logic [63:0] cursor;
        logic [31:0] seq;
        int pick;
        cursor = 64'($urandom_range(0, cur_max));
        send_item(0, cursor[31:0]);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                cursor = cursor + $urandom_range(1, 3);
                if (cursor > {32'd0, cur_max}) cursor = cursor - {32'd0, cur_max} - 1;
                send_item(1, cursor[31:0]);
            end else if (pick < 84) begin
                seq = cursor[31:0] - $urandom_range(0, 6);
                send_item(1, seq);
            end else if (pick < 96) begin
                send_item(1, $urandom());
            end else if (pick < 98) begin
                cursor = 64'($urandom_range(0, cur_max));
                send_item(0, cursor[31:0]);
            end else begin
                send_item(0, $urandom());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_item(1, 32'd5);
        send_item(0, 32'd70000);
        send_item(0, 32'd65535);
        send_item(1, 32'd65535);
        send_item(1, 32'd0);
        send_item(1, 32'd40000);
        send_item(1, 32'd1);
        send_item(0, 32'd0);
        send_item(0, 32'd8192);
        send_item(1, 32'd8191);
        send_item(1, 32'd8192);
        send_item(1, 32'd49151);
        send_item(1, 32'd8192);
        send_item(1, 32'd16384);
        send_item(0, 32'hFFFF_FFFF);
        send_item(1, 32'hFFFF_FFFF);

        send_idle_pct = 14;
        recv_idle_pct = 74;
        write_max(32'd1);
        random_run(40);
        write_max(32'hFFFF_FFFF);
        random_run(120);
        drain();
        send_idle_pct = 74;
        recv_idle_pct = 14;
        write_max(32'd63);
        random_run(150);
        write_max(32'd1000);
        random_run(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max(32'd65535);
        random_run(250);
        write_max(32'hFFFF_FFFF);
        random_run(90);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
